// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the flame and ember PWM block.
// Depends on nothing; each use expects signals named clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent holds in one cycle and the consequent in the next.
`define FE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// The expression holds at every clock edge out of reset.
`define FE_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant check failed");

`endif

// ===== rtl/fel_pkg.sv =====
// Package for the flame and ember PWM block: widths, reset constants,
// gear table and the ember pattern ROM. Depends on nothing.
package fel_pkg;

  localparam int PATTERN_STEPS = 46;
  localparam int IDX_W         = 6;
  localparam int DUTY_W        = 10;
  localparam int LEVEL_W       = 7;
  localparam int HOLD_W        = 5;
  localparam int SPEED_W       = 9;
  localparam int TIMER_W       = 10;
  localparam int PERIOD_W      = 8;
  localparam int CHANNELS      = 2;

  typedef logic [DUTY_W-1:0]   duty_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [LEVEL_W-1:0]  level_t;
  typedef logic [HOLD_W-1:0]   hold_t;
  typedef logic [SPEED_W-1:0]  speed_t;
  typedef logic [TIMER_W-1:0]  timer_t;
  typedef logic [PERIOD_W-1:0] period_t;

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_FLAME_PERIOD = 1'b0,
    REG_EMBER_PERIOD = 1'b1
  } reg_idx_t;

  localparam period_t FLAME_PERIOD_RST = 8'd200;
  localparam period_t EMBER_PERIOD_RST = 8'd100;
  localparam idx_t    EMBER1_IDX_RST   = 6'd17;
  localparam idx_t    EMBER2_IDX_RST   = 6'd0;
  localparam level_t  EMBER1_LEVEL_RST = 7'd49;
  localparam level_t  EMBER2_LEVEL_RST = 7'd100;
  localparam duty_t   GLOW_DUTY        = 10'd100;
  localparam duty_t   FULL_DUTY        = 10'd999;
  localparam level_t  LEVEL_MAX        = 7'd100;
  localparam duty_t   LEVEL_SCALE      = 10'd10;

  // Flame duty for each gear (gear units times 100); gears six and seven are off.
  localparam duty_t GEAR_DUTY [8] = '{
    10'd0, 10'd1000, 10'd700, 10'd400, 10'd200, 10'd100, 10'd0, 10'd0
  };

  localparam speed_t SPEED_ROM [PATTERN_STEPS] = '{
    9'd25, 9'd100, 9'd50, 9'd175, 9'd25, 9'd25, 9'd55, 9'd40, 9'd30, 9'd50,
    9'd50, 9'd75, 9'd100, 9'd20, 9'd5, 9'd62, 9'd88, 9'd25, 9'd25, 9'd75,
    9'd25, 9'd55, 9'd20, 9'd20, 9'd80, 9'd150, 9'd275, 9'd20, 9'd30, 9'd75,
    9'd25, 9'd50, 9'd25, 9'd25, 9'd20, 9'd80, 9'd250, 9'd70, 9'd130, 9'd50,
    9'd25, 9'd50, 9'd50, 9'd200, 9'd25, 9'd25
  };

  localparam level_t TARGET_ROM [PATTERN_STEPS] = '{
    7'd100, 7'd10, 7'd10, 7'd70, 7'd100, 7'd100, 7'd27, 7'd31, 7'd87, 7'd100,
    7'd100, 7'd60, 7'd20, 7'd10, 7'd10, 7'd83, 7'd49, 7'd49, 7'd20, 7'd100,
    7'd100, 7'd47, 7'd50, 7'd47, 7'd100, 7'd100, 7'd45, 7'd35, 7'd100, 7'd100,
    7'd90, 7'd80, 7'd80, 7'd75, 7'd75, 7'd10, 7'd95, 7'd84, 7'd10, 7'd10,
    7'd30, 7'd50, 7'd50, 7'd90, 7'd100, 7'd100
  };

  localparam hold_t HOLD_ROM [PATTERN_STEPS] = '{
    5'd0, 5'd2, 5'd0, 5'd5, 5'd2, 5'd0, 5'd0, 5'd20, 5'd0, 5'd7,
    5'd0, 5'd3, 5'd5, 5'd4, 5'd0, 5'd0, 5'd5, 5'd0, 5'd0, 5'd2,
    5'd0, 5'd2, 5'd13, 5'd13, 5'd3, 5'd0, 5'd10, 5'd4, 5'd0, 5'd0,
    5'd5, 5'd10, 5'd0, 5'd10, 5'd0, 5'd2, 5'd5, 5'd12, 5'd3, 5'd0,
    5'd0, 5'd5, 5'd0, 5'd10, 5'd5, 5'd0
  };

  // Pattern ROM reads; entries past the defined pattern read as zero.
  function automatic speed_t rom_speed(idx_t idx);
    speed_t val;
    val = '0;
    if (int'(idx) < PATTERN_STEPS) begin
      val = SPEED_ROM[idx];
    end
    return val;
  endfunction

  function automatic level_t rom_target(idx_t idx);
    level_t val;
    val = '0;
    if (int'(idx) < PATTERN_STEPS) begin
      val = TARGET_ROM[idx];
    end
    return val;
  endfunction

  function automatic hold_t rom_hold(idx_t idx);
    hold_t val;
    val = '0;
    if (int'(idx) < PATTERN_STEPS) begin
      val = HOLD_ROM[idx];
    end
    return val;
  endfunction

  // Entry before idx, wrapping from the first entry to the last.
  function automatic idx_t prev_index(idx_t idx);
    idx_t val;
    if (idx == '0) begin
      val = IDX_W'(PATTERN_STEPS - 1);
    end else begin
      val = idx - 1'b1;
    end
    return val;
  endfunction

  // Entry after idx, wrapping to the first entry at the pattern end.
  function automatic idx_t next_index(idx_t idx);
    logic [IDX_W:0] inc;
    idx_t           val;
    inc = {1'b0, idx} + 1'b1;
    if (int'(inc) >= PATTERN_STEPS) begin
      val = '0;
    end else begin
      val = inc[IDX_W-1:0];
    end
    return val;
  endfunction

  // State of one ember channel together with a duty-update flag.
  typedef struct packed {
    period_t prescale;
    timer_t  timer;
    idx_t    index;
    hold_t   hold;
    level_t  level;
    logic    duty_upd;
    duty_t   duty;
  } ember_step_t;

endpackage

// ===== rtl/flame_ember_led_pattern_pwm.sv =====
// Top level of the flame and ember PWM block: tick request handling, flame
// reload, ember pattern stepping and the result register. Uses fel_pkg.
//
// Usage: one tick request per millisecond arrives on the input channel
// (in_valid/in_ready) carrying the run, flame-level, heat and lock flags.
// Each accepted request yields exactly one result request on the output
// channel (out_valid/out_ready) with the flame duty, both ember duties and
// the motor bit as they stand after that tick.
// The result of an accepted request is presented from the cycle after its
// acceptance. Throughput is one request per cycle while the receiver takes
// each result; state update and pattern ROM reads complete in the single
// combinational pass in front of the state registers (the result register).
// When the receiver stalls, the result holds and a new tick is accepted only
// in the cycle in which the pending result is taken, so no result is lost.
// The two period registers are written through cfg_write/cfg_index/cfg_data
// and should only be changed while no request is in flight.
// Reset (rst, synchronous, active high) restores both periods to their
// defaults, clears duties, counters and the motor bit, sets the ember
// channels to their start points and empties the result register.
module flame_ember_led_pattern_pwm (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_write,
  input  fel_pkg::reg_idx_t    cfg_index,
  input  fel_pkg::period_t     cfg_data,
  // tick request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 running,
  input  logic [2:0]           flame_level,
  input  logic                 heat_on,
  input  logic                 heat_locked,
  input  logic                 ember_follow,
  input  logic                 lock_blank,
  input  logic                 lock_full,
  // result request channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output fel_pkg::duty_t       ember1_duty,
  output fel_pkg::duty_t       flame_duty,
  output fel_pkg::duty_t       ember2_duty,
  output logic                 motor_on
);
  import fel_pkg::*;

  // Configuration registers.
  period_t flame_period;
  period_t ember_period;

  // Block state; the duty and motor registers also form the result.
  period_t flame_ticks;
  duty_t   flame_pwm;
  logic    motor_bit;
  duty_t   ember_pwm     [CHANNELS];
  period_t ember_prescale[CHANNELS];
  timer_t  ember_timer   [CHANNELS];
  idx_t    ember_index   [CHANNELS];
  hold_t   ember_hold    [CHANNELS];
  level_t  ember_level   [CHANNELS];

  period_t flame_ticks_next;
  duty_t   flame_pwm_next;
  logic    motor_bit_next;
  duty_t   ember_pwm_next     [CHANNELS];
  period_t ember_prescale_next[CHANNELS];
  timer_t  ember_timer_next   [CHANNELS];
  idx_t    ember_index_next   [CHANNELS];
  hold_t   ember_hold_next    [CHANNELS];
  level_t  ember_level_next   [CHANNELS];

  ember_step_t ch_step[CHANNELS];

  logic accept;

  // A new tick is taken whenever the result register is empty or its
  // content leaves in this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      flame_period <= FLAME_PERIOD_RST;
      ember_period <= EMBER_PERIOD_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FLAME_PERIOD: flame_period <= cfg_data;
        REG_EMBER_PERIOD: ember_period <= cfg_data;
        default:          flame_period <= flame_period;
      endcase
    end
  end

  // One pattern step per ember channel. A channel only moves when its
  // prescaler reaches the ember period; the speed timer then counts down,
  // and on expiry the next pattern entry is loaded. The level creeps by one
  // toward the target of the current entry once its hold count is reached.
  always_comb begin
    period_t pre_inc;
    hold_t   hold_base;
    hold_t   hold_inc;
    idx_t    entry;
    level_t  target;
    logic [DUTY_W+LEVEL_W-1:0] scaled;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      pre_inc   = ember_prescale[ch] + 1'b1;
      hold_base = ember_hold[ch];
      hold_inc  = '0;
      entry     = '0;
      target    = '0;
      scaled    = '0;
      ch_step[ch].prescale = pre_inc;
      ch_step[ch].timer    = ember_timer[ch];
      ch_step[ch].index    = ember_index[ch];
      ch_step[ch].hold     = ember_hold[ch];
      ch_step[ch].level    = ember_level[ch];
      ch_step[ch].duty_upd = 1'b0;
      ch_step[ch].duty     = ember_pwm[ch];
      if (pre_inc >= ember_period) begin
        ch_step[ch].prescale = '0;
        ch_step[ch].duty_upd = 1'b1;
        if (ember_timer[ch] != '0) begin
          ch_step[ch].timer = ember_timer[ch] - 1'b1;
        end else begin
          ch_step[ch].timer = {rom_speed(ember_index[ch]), 1'b0};
          ch_step[ch].index = next_index(ember_index[ch]);
          hold_base         = rom_hold(prev_index(ch_step[ch].index));
        end
        entry    = prev_index(ch_step[ch].index);
        target   = rom_target(entry);
        hold_inc = hold_base + 1'b1;
        ch_step[ch].hold = hold_inc;
        if (hold_inc >= rom_hold(entry)) begin
          ch_step[ch].hold = '0;
          if (target > ember_level[ch]) begin
            ch_step[ch].level = ember_level[ch] + 1'b1;
          end else if (target < ember_level[ch]) begin
            ch_step[ch].level = ember_level[ch] - 1'b1;
          end
        end
        scaled = DUTY_W'(ch_step[ch].level) * LEVEL_SCALE;
        ch_step[ch].duty = scaled[DUTY_W-1:0];
      end
    end
  end

  // Whole-tick update: standby, flame off with glow, or flame running with
  // periodic reload and either follow mode or the ember pattern. The lock
  // flags override the ember duties last, except in standby.
  always_comb begin
    period_t ticks_inc;
    ticks_inc        = flame_ticks + 1'b1;
    flame_ticks_next = flame_ticks;
    flame_pwm_next   = flame_pwm;
    motor_bit_next   = motor_bit;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      ember_pwm_next[ch]      = ember_pwm[ch];
      ember_prescale_next[ch] = ember_prescale[ch];
      ember_timer_next[ch]    = ember_timer[ch];
      ember_index_next[ch]    = ember_index[ch];
      ember_hold_next[ch]     = ember_hold[ch];
      ember_level_next[ch]    = ember_level[ch];
    end

    if (!running) begin
      flame_pwm_next      = '0;
      motor_bit_next      = 1'b0;
      ember_pwm_next[0]   = '0;
      ember_pwm_next[1]   = '0;
      ember_index_next[0] = EMBER1_IDX_RST;
      ember_index_next[1] = EMBER2_IDX_RST;
      ember_level_next[0] = EMBER1_LEVEL_RST;
      ember_level_next[1] = EMBER2_LEVEL_RST;
    end else begin
      if (flame_level == '0) begin
        flame_pwm_next = '0;
        motor_bit_next = 1'b0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
          ember_pwm_next[ch] = (heat_on && !heat_locked) ? GLOW_DUTY : '0;
        end
      end else begin
        if (ticks_inc >= flame_period) begin
          flame_ticks_next = '0;
          motor_bit_next   = 1'b1;
          flame_pwm_next   = GEAR_DUTY[flame_level];
          if (ember_follow) begin
            ember_pwm_next[0] = GEAR_DUTY[flame_level];
            ember_pwm_next[1] = GEAR_DUTY[flame_level];
          end
        end else begin
          flame_ticks_next = ticks_inc;
        end
        if (!ember_follow) begin
          for (int ch = 0; ch < CHANNELS; ch++) begin
            ember_prescale_next[ch] = ch_step[ch].prescale;
            ember_timer_next[ch]    = ch_step[ch].timer;
            ember_index_next[ch]    = ch_step[ch].index;
            ember_hold_next[ch]     = ch_step[ch].hold;
            ember_level_next[ch]    = ch_step[ch].level;
            if (ch_step[ch].duty_upd) begin
              ember_pwm_next[ch] = ch_step[ch].duty;
            end
          end
        end
      end
      if (lock_blank) begin
        ember_pwm_next[0] = '0;
        ember_pwm_next[1] = '0;
      end else if (lock_full) begin
        ember_pwm_next[0] = FULL_DUTY;
        ember_pwm_next[1] = FULL_DUTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      flame_ticks <= '0;
      flame_pwm   <= '0;
      motor_bit   <= 1'b0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        ember_pwm[ch]      <= '0;
        ember_prescale[ch] <= '0;
        ember_timer[ch]    <= '0;
        ember_hold[ch]     <= '0;
      end
      ember_index[0] <= EMBER1_IDX_RST;
      ember_index[1] <= EMBER2_IDX_RST;
      ember_level[0] <= EMBER1_LEVEL_RST;
      ember_level[1] <= EMBER2_LEVEL_RST;
    end else begin
      if (accept) begin
        out_valid   <= 1'b1;
        flame_ticks <= flame_ticks_next;
        flame_pwm   <= flame_pwm_next;
        motor_bit   <= motor_bit_next;
        for (int ch = 0; ch < CHANNELS; ch++) begin
          ember_pwm[ch]      <= ember_pwm_next[ch];
          ember_prescale[ch] <= ember_prescale_next[ch];
          ember_timer[ch]    <= ember_timer_next[ch];
          ember_index[ch]    <= ember_index_next[ch];
          ember_hold[ch]     <= ember_hold_next[ch];
          ember_level[ch]    <= ember_level_next[ch];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign ember1_duty = ember_pwm[0];
  assign ember2_duty = ember_pwm[1];
  assign flame_duty  = flame_pwm;
  assign motor_on    = motor_bit;

`include "assert_macros.svh"

  `FE_ASSERT_NEXT(a_accept_gives_result, accept, out_valid)
  `FE_ASSERT_NEXT(a_standby_clears, accept && !running,
    flame_duty == '0 && ember1_duty == '0 && ember2_duty == '0 && !motor_on)
  `FE_ASSERT_NEXT(a_blank_wins, accept && running && lock_blank,
    ember1_duty == '0 && ember2_duty == '0)
  `FE_ASSERT_ALWAYS(a_index_in_pattern,
    int'(ember_index[0]) < PATTERN_STEPS && int'(ember_index[1]) < PATTERN_STEPS)
  `FE_ASSERT_ALWAYS(a_level_bounded,
    ember_level[0] <= LEVEL_MAX && ember_level[1] <= LEVEL_MAX)

endmodule
